>>> rtl/dsps_pkg.sv
`timescale 1ns / 1ps
// dsps_pkg: command codes, half-step coil table and default sizes
// for the dual stepper position sequencer; depends on nothing

package dsps_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int PHASE_COUNT           = 8;
   localparam int PHASE_BITS            = $clog2(PHASE_COUNT);
   localparam int COIL_BITS             = 4;
   localparam int VALUE_BITS            = 16;
   localparam int NOW_BITS              = 16;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_MOVE_BY  = 3'd1,
      CMD_GO_TO    = 3'd2,
      CMD_SET_POS  = 3'd3,
      CMD_ENABLE   = 3'd4,
      CMD_DISABLE  = 3'd5
   } cmd_type;

   localparam logic [COIL_BITS-1:0] HALF_STEP_TABLE [PHASE_COUNT] = '{
      4'h2, 4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6
   };

   function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [PHASE_BITS-1:0] phase);
      return HALF_STEP_TABLE[phase];
   endfunction

endpackage

>>> rtl/dual_stepper_position_sequencer.sv
`timescale 1ns / 1ps
// dual_stepper_position_sequencer: two-motor half-step position sequencer
// depends on dsps_pkg for command codes and the coil table
//
//  channel | direction | ports                                  | words
//  req     | in        | req_valid, req_stall, req_cmd, req_value | one command
//  rsp     | out       | rsp_valid, rsp_stall, rsp_*             | one status per command
//
// an accepted req word becomes its rsp word via the input register, then
// the state update and result register; one word per cycle sustained while rsp_stall is low
// synchronous active-high reset clears positions, targets, flag and coils
// req_stall rises only while both stages hold words and rsp_stall is high

module dual_stepper_position_sequencer
#(
   parameter int POSITION_BITS = dsps_pkg::POSITION_BITS_DEFAULT
)
(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_cmd,
   input  logic signed [dsps_pkg::VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dsps_pkg::COIL_BITS-1:0]       rsp_left_coils,
   output logic [dsps_pkg::COIL_BITS-1:0]       rsp_right_coils,
   output logic                                 rsp_drivers_on,
   output logic                                 rsp_moving,
   output logic signed [dsps_pkg::NOW_BITS-1:0] rsp_left_now,
   output logic signed [dsps_pkg::NOW_BITS-1:0] rsp_right_now
);

   import dsps_pkg::*;

   localparam int P = POSITION_BITS;

   // input stage
   logic                  s1_valid_ff;
   logic [2:0]            cmd_ff;
   logic [VALUE_BITS-1:0] value_ff;

   // motor state
   logic [P-1:0]         left_pos_ff, left_pos_in;
   logic [P-1:0]         right_pos_ff, right_pos_in;
   logic [P-1:0]         left_tgt_ff, left_tgt_in;
   logic [P-1:0]         right_tgt_ff, right_tgt_in;
   logic                 enable_ff, enable_in;
   logic [COIL_BITS-1:0] left_pat_ff, left_pat_in;
   logic [COIL_BITS-1:0] right_pat_ff, right_pat_in;

   // result stage
   logic                 rsp_valid_ff;
   logic [COIL_BITS-1:0] rsp_left_coils_ff, rsp_right_coils_ff;
   logic                 rsp_drivers_on_ff, rsp_moving_ff;
   logic [NOW_BITS-1:0]  rsp_left_now_ff, rsp_right_now_ff;

   logic                 out_free;
   logic                 s1_fire;
   logic [P-1:0]         value_ext;
   logic [P-1:0]         left_step, right_step;
   logic                 left_moves, right_moves;
   logic [NOW_BITS-1:0]  left_now_in, right_now_in;

   function automatic logic [P-1:0] step_toward(input logic [P-1:0] pos,
                                                input logic [P-1:0] tgt);
      logic signed [P:0] diff;
      logic              far;
      logic [P-1:0]      amount;
      diff   = $signed({tgt[P-1], tgt}) - $signed({pos[P-1], pos});
      far    = (diff > $signed((P+1)'(1))) || (diff < -$signed((P+1)'(1)));
      amount = (far && !pos[0]) ? P'(2) : P'(1);
      if (diff == '0) begin
         return pos;
      end else if (diff < 0) begin
         return pos - amount;
      end else begin
         return pos + amount;
      end
   endfunction

   generate
      if (P >= VALUE_BITS) begin : g_wide
         assign value_ext    = {{(P-VALUE_BITS){value_ff[VALUE_BITS-1]}}, value_ff};
         assign left_now_in  = left_pos_in[NOW_BITS-1:0];
         assign right_now_in = right_pos_in[NOW_BITS-1:0];
      end else begin : g_narrow
         assign value_ext    = value_ff[P-1:0];
         assign left_now_in  = {{(NOW_BITS-P){1'b0}}, left_pos_in};
         assign right_now_in = {{(NOW_BITS-P){1'b0}}, right_pos_in};
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   assign left_step   = step_toward(left_pos_ff, left_tgt_ff);
   assign right_step  = step_toward(right_pos_ff, right_tgt_ff);
   assign left_moves  = left_pos_ff != left_tgt_ff;
   assign right_moves = right_pos_ff != right_tgt_ff;

   always_comb begin
      left_pos_in  = left_pos_ff;
      right_pos_in = right_pos_ff;
      left_tgt_in  = left_tgt_ff;
      right_tgt_in = right_tgt_ff;
      enable_in    = enable_ff;
      left_pat_in  = left_pat_ff;
      right_pat_in = right_pat_ff;
      case (cmd_type'(cmd_ff))
         CMD_TICK: begin
            left_pos_in  = left_step;
            right_pos_in = right_step;
            if (left_moves || right_moves) begin
               enable_in    = 1'b1;
               left_pat_in  = coil_pattern(left_step[PHASE_BITS-1:0]);
               right_pat_in = coil_pattern(right_step[PHASE_BITS-1:0]);
            end
         end
         CMD_MOVE_BY: begin
            left_tgt_in  = left_tgt_ff + value_ext;
            right_tgt_in = right_tgt_ff + value_ext;
         end
         CMD_GO_TO: begin
            left_tgt_in  = value_ext;
            right_tgt_in = value_ext;
         end
         CMD_SET_POS: begin
            left_tgt_in  = value_ext;
            right_tgt_in = value_ext;
            left_pos_in  = value_ext;
            right_pos_in = value_ext;
         end
         CMD_ENABLE: begin
            enable_in    = 1'b1;
            left_pat_in  = coil_pattern(left_pos_ff[PHASE_BITS-1:0]);
            right_pat_in = coil_pattern(right_pos_ff[PHASE_BITS-1:0]);
         end
         CMD_DISABLE: begin
            enable_in    = 1'b0;
            left_pat_in  = '0;
            right_pat_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_pos_ff  <= '0;
         right_pos_ff <= '0;
         left_tgt_ff  <= '0;
         right_tgt_ff <= '0;
         enable_ff    <= 1'b0;
         left_pat_ff  <= '0;
         right_pat_ff <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire) begin
            left_pos_ff  <= left_pos_in;
            right_pos_ff <= right_pos_in;
            left_tgt_ff  <= left_tgt_in;
            right_tgt_ff <= right_tgt_in;
            enable_ff    <= enable_in;
            left_pat_ff  <= left_pat_in;
            right_pat_ff <= right_pat_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
      end
      if (s1_fire) begin
         rsp_left_coils_ff  <= left_pat_in;
         rsp_right_coils_ff <= right_pat_in;
         rsp_drivers_on_ff  <= enable_in;
         rsp_moving_ff      <= (left_pos_in != left_tgt_in) || (right_pos_in != right_tgt_in);
         rsp_left_now_ff    <= left_now_in;
         rsp_right_now_ff   <= right_now_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_coils  = rsp_left_coils_ff;
   assign rsp_right_coils = rsp_right_coils_ff;
   assign rsp_drivers_on  = rsp_drivers_on_ff;
   assign rsp_moving      = rsp_moving_ff;
   assign rsp_left_now    = $signed(rsp_left_now_ff);
   assign rsp_right_now   = $signed(rsp_right_now_ff);

endmodule

>>> verif/tb_dual_stepper_position_sequencer.sv
`timescale 1ns / 1ps
// tb_dual_stepper_position_sequencer: self-checking bench for the dual stepper sequencer,
// a directed command table then random command sequences, mostly moves and ticks, checked by a predictor
// depends on dsps_pkg and dual_stepper_position_sequencer from rtl

module tb_dual_stepper_position_sequencer;
   import dsps_pkg::*;

   localparam int PB            = POSITION_BITS_DEFAULT;
   localparam int RANDOM_WORDS  = 1700;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 3000;
   localparam int DRAIN_CYCLES  = 6;
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;
   localparam logic [COIL_BITS-1:0] COIL_STEPS [8] = '{
      4'h2, 4'hA, 4'h8, 4'h9, 4'h1, 4'h5, 4'h4, 4'h6
   };

   typedef struct packed {
      logic [COIL_BITS-1:0] left_coils;
      logic [COIL_BITS-1:0] right_coils;
      logic                 drivers_on;
      logic                 moving;
      logic [NOW_BITS-1:0]  left_now;
      logic [NOW_BITS-1:0]  right_now;
   } status_word_type;

   typedef struct packed {
      logic [2:0]      cmd;
      logic [15:0]     value;
      logic            known;
      status_word_type status;
   } stim_row_type;

   localparam stim_row_type DIRECTED [26] = '{
      '{CMD_TICK,    16'h0000, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{CMD_ENABLE,  16'h0000, 1'b1, '{4'h2, 4'h2, 1'b1, 1'b0, 16'h0000, 16'h0000}},
      '{CMD_DISABLE, 16'hFFFF, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0000, 16'h0000}},
      '{CMD_SET_POS, 16'h7FFF, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h7FFF, 16'h7FFF}},
      '{CMD_GO_TO,   16'h8000, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF}},
      '{CMD_TICK,    16'h0000, 1'b1, '{4'h4, 4'h4, 1'b1, 1'b1, 16'h7FFE, 16'h7FFE}},
      '{CMD_TICK,    16'hFFFF, 1'b0, '0},
      '{CMD_SET_POS, 16'h8000, 1'b0, '0},
      '{CMD_GO_TO,   16'h7FFF, 1'b0, '0},
      '{CMD_TICK,    16'h0000, 1'b0, '0},
      '{CMD_MOVE_BY, 16'h0001, 1'b0, '0},
      '{CMD_TICK,    16'h0000, 1'b0, '0},
      '{CMD_MOVE_BY, 16'h8000, 1'b0, '0},
      '{CMD_MOVE_BY, 16'h7FFF, 1'b0, '0},
      '{CMD_SET_POS, 16'h0005, 1'b0, '0},
      '{CMD_GO_TO,   16'h0006, 1'b0, '0},
      '{CMD_TICK,    16'h0000, 1'b0, '0},
      '{CMD_SET_POS, 16'h0004, 1'b0, '0},
      '{CMD_GO_TO,   16'h0005, 1'b0, '0},
      '{CMD_TICK,    16'h0000, 1'b0, '0},
      '{CMD_TICK,    16'h0000, 1'b0, '0},
      '{CMD_DISABLE, 16'h0000, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0005, 16'h0005}},
      '{CMD_TICK,    16'h0000, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0005, 16'h0005}},
      '{CMD_SPARE_A, 16'hFFFF, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0005, 16'h0005}},
      '{CMD_SPARE_B, 16'h1234, 1'b1, '{4'h0, 4'h0, 1'b0, 1'b0, 16'h0005, 16'h0005}},
      '{CMD_ENABLE,  16'h0000, 1'b1, '{4'h5, 4'h5, 1'b1, 1'b0, 16'h0005, 16'h0005}}
   };

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [2:0]                  req_cmd;
   logic signed [VALUE_BITS-1:0] req_value;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [COIL_BITS-1:0]        rsp_left_coils;
   logic [COIL_BITS-1:0]        rsp_right_coils;
   logic                        rsp_drivers_on;
   logic                        rsp_moving;
   logic signed [NOW_BITS-1:0]  rsp_left_now;
   logic signed [NOW_BITS-1:0]  rsp_right_now;

   // predicted motor state
   logic [PB-1:0]        pos_l, pos_r, tgt_l, tgt_r;
   logic                 drivers_en;
   logic [COIL_BITS-1:0] coils_l, coils_r;

   status_word_type expected_status [$];
   int  mismatches;
   int  commands_sent;
   bit  sender_burst;

   dual_stepper_position_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_coils  (rsp_left_coils),
      .rsp_right_coils (rsp_right_coils),
      .rsp_drivers_on  (rsp_drivers_on),
      .rsp_moving      (rsp_moving),
      .rsp_left_now    (rsp_left_now),
      .rsp_right_now   (rsp_right_now)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic step_toward(input logic [PB-1:0] pos, input logic [PB-1:0] tgt,
                                        output logic [PB-1:0] next_pos);
      longint        p, t, span;
      logic [PB-1:0] amount;
      p = longint'($signed(pos));
      t = longint'($signed(tgt));
      next_pos = pos;
      if (p == t) return 1'b0;
      span = (p > t) ? p - t : t - p;
      amount = (span > 1 && !pos[0]) ? PB'(2) : PB'(1);
      next_pos = (p > t) ? pos - amount : pos + amount;
      return 1'b1;
   endfunction

   function automatic void latch_coils();
      drivers_en = 1'b1;
      coils_l = COIL_STEPS[pos_l[2:0]];
      coils_r = COIL_STEPS[pos_r[2:0]];
   endfunction

   function automatic status_word_type apply_command(input logic [2:0] c, input logic [15:0] v);
      logic signed [PB-1:0] val;
      logic                 moved_l, moved_r;
      status_word_type      s;
      val = $signed(v);
      case (c)
         CMD_TICK: begin
            moved_l = step_toward(pos_l, tgt_l, pos_l);
            moved_r = step_toward(pos_r, tgt_r, pos_r);
            if (moved_l || moved_r) latch_coils();
         end
         CMD_MOVE_BY: begin
            tgt_l = tgt_l + val;
            tgt_r = tgt_r + val;
         end
         CMD_GO_TO: begin
            tgt_l = val;
            tgt_r = val;
         end
         CMD_SET_POS: begin
            tgt_l = val;
            tgt_r = val;
            pos_l = val;
            pos_r = val;
         end
         CMD_ENABLE: latch_coils();
         CMD_DISABLE: begin
            drivers_en = 1'b0;
            coils_l = '0;
            coils_r = '0;
         end
         default: ;
      endcase
      s.left_coils  = coils_l;
      s.right_coils = coils_r;
      s.drivers_on  = drivers_en;
      s.moving      = (pos_l != tgt_l) || (pos_r != tgt_r);
      s.left_now    = pos_l[NOW_BITS-1:0];
      s.right_now   = pos_r[NOW_BITS-1:0];
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // mostly near the given position, sometimes anywhere
   function automatic logic [15:0] near_value(input logic [PB-1:0] base);
      if ($urandom_range(0, 99) < 85) return 16'(base) + 16'($urandom_range(0, 60)) - 16'd30;
      return 16'($urandom);
   endfunction

   task automatic send_word(input logic [2:0] c, input logic [15:0] v, input logic known,
                            input status_word_type typed_status);
      int              gap;
      status_word_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= c;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_command(c, v);
      expected_status.push_back(known ? typed_status : predicted);
      if (c < CMD_SPARE_A) commands_sent++;
   endtask

   // stimulus
   initial begin
      int i, n, pick;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_cmd    = CMD_TICK;
      req_value  = '0;
      pos_l = '0; pos_r = '0; tgt_l = '0; tgt_r = '0;
      drivers_en = 1'b0;
      coils_l = '0; coils_r = '0;
      mismatches    = 0;
      commands_sent = 0;
      sender_burst  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(DIRECTED); i++)
         send_word(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].known, DIRECTED[i].status);

      commands_sent = 0;
      while (commands_sent < RANDOM_WORDS) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 1))
               send_word(CMD_MOVE_BY, near_value('0), 1'b0, '0);
            else
               send_word(CMD_GO_TO, near_value(tgt_l), 1'b0, '0);
            n = $urandom_range(1, 28);
            repeat (n) send_word(CMD_TICK, 16'($urandom), 1'b0, '0);
            if ($urandom_range(0, 9) == 0) send_word(CMD_DISABLE, 16'($urandom), 1'b0, '0);
         end else if (pick < 65) begin
            send_word(CMD_SET_POS, near_value(pos_l), 1'b0, '0);
         end else if (pick < 72) begin
            send_word(CMD_ENABLE, 16'($urandom), 1'b0, '0);
         end else if (pick < 79) begin
            send_word(CMD_DISABLE, 16'($urandom), 1'b0, '0);
         end else if (pick < 83) begin
            send_word($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, 16'($urandom), 1'b0, '0);
         end else if (pick < 90) begin
            send_word(CMD_TICK, 16'($urandom), 1'b0, '0);
         end else begin
            send_word(3'($urandom_range(0, 7)), 16'($urandom), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // result checking, receiver stalls and watchdog
   initial begin
      int              idle_cycles, hold_left, hold_mark, stall_run, stall_mode, cycle;
      status_word_type got, want;
      idle_cycles = 0;
      hold_left   = 0;
      hold_mark   = 400;
      stall_run   = 0;
      stall_mode  = 0;
      cycle       = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               got = '{rsp_left_coils, rsp_right_coils, rsp_drivers_on, rsp_moving,
                       rsp_left_now, rsp_right_now};
               if (expected_status.size() == 0) begin
                  $error("status word with none expected");
                  mismatches++;
               end else begin
                  want = expected_status.pop_front();
                  if (got.left_coils !== want.left_coils) begin
                     $error("left_coils: expected %h, got %h", want.left_coils, got.left_coils);
                     mismatches++;
                  end
                  if (got.right_coils !== want.right_coils) begin
                     $error("right_coils: expected %h, got %h", want.right_coils,
                            got.right_coils);
                     mismatches++;
                  end
                  if (got.drivers_on !== want.drivers_on) begin
                     $error("drivers_on: expected %b, got %b", want.drivers_on, got.drivers_on);
                     mismatches++;
                  end
                  if (got.moving !== want.moving) begin
                     $error("moving: expected %b, got %b", want.moving, got.moving);
                     mismatches++;
                  end
                  if (got.left_now !== want.left_now) begin
                     $error("left_now: expected %h, got %h", want.left_now, got.left_now);
                     mismatches++;
                  end
                  if (got.right_now !== want.right_now) begin
                     $error("right_now: expected %h, got %h", want.right_now, got.right_now);
                     mismatches++;
                  end
               end
            end
            if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
               idle_cycles = 0;
            else
               idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("end of test: mismatches");
               $finish;
            end
         end

         if (cycle % 128 == 0) stall_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (commands_sent >= hold_mark) begin
            // long hold so the pipe fills and req_stall rises
            hold_left = LONG_HOLD - 1;
            hold_mark += 700;
            rsp_stall <= 1'b1;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_stall <= 1'b1;
         end else if (stall_mode == 0) begin
            rsp_stall <= 1'b0;
         end else if (stall_mode == 2 && $urandom_range(0, 99) < 4) begin
            stall_run = $urandom_range(10, 40);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
      end
   end

endmodule

>>> sim.f
rtl/dsps_pkg.sv
rtl/dual_stepper_position_sequencer.sv
verif/tb_dual_stepper_position_sequencer.sv
